// ===== hw/rtl/pmnm_pkg.sv =====
// Shared types and constants for the periodic mirror node match block.
// No dependencies; every other file in this block but pmnm_ram imports it.
package pmnm_pkg;

    // Default sizing of the node table.
    localparam int MAX_NODES_DEF   = 1024;
    localparam int COORD_WIDTH_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int IDX_W      = 10;
    localparam int IN_COORD_W = 16;
    localparam int COUNT_W    = 11;

    // Item kinds carried in s_tuser.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Finished result handed from the controller to the output register.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             found;
    } pmnm_res_t;

endpackage

// ===== hw/rtl/pmnm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pmnm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/pmnm_ctrl.sv =====
// Sequencer for the node table: stores written nodes, classifies queried
// nodes and scans the table for mirror partners. Depends on pmnm_pkg.
module pmnm_ctrl
    import pmnm_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Item input.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [IDX_W-1:0]              s_idx,
    input  logic signed [IN_COORD_W-1:0]  s_x,
    input  logic signed [IN_COORD_W-1:0]  s_y,
    // Configuration.
    input  logic [COUNT_W-1:0]            node_count,
    // Table memory.
    output logic                          ram_we,
    output logic [$clog2(MAX_NODES)-1:0]  ram_waddr,
    output logic [2*COORD_WIDTH-1:0]      ram_wdata,
    output logic [$clog2(MAX_NODES)-1:0]  ram_raddr,
    input  logic [2*COORD_WIDTH-1:0]      ram_rdata,
    // Result handoff.
    output pmnm_res_t                     res,
    input  logic                          res_take
);

    localparam int CW     = COORD_WIDTH;
    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] ONE_V = CW'(64'd1 << (CW - 2));
    localparam logic [CW-1:0] NEG_V = CW'(0) - ONE_V;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t           state_reg;
    logic [CW:0]      tx_reg;
    logic [CW:0]      ty_reg;
    logic             chain_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             pend_valid_reg;
    logic [CNT_W-1:0] pend_idx_reg;
    logic [IDX_W-1:0] self_idx_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             res_found_reg;

    logic             accept;
    logic [31:0]      idx_ext;
    logic             idx_in_range;
    logic [31:0]      lim_ext;
    logic [CNT_W-1:0] lim;
    logic [CW-1:0]    rd_x;
    logic [CW-1:0]    rd_y;
    logic [CW:0]      rd_x_ext;
    logic [CW:0]      rd_y_ext;
    logic             hit;
    logic [31:0]      pend_idx_ext;

    // Input decode and scan limit.
    assign accept       = s_valid && s_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign idx_ext      = {{(32 - IDX_W){1'b0}}, s_idx};
    assign idx_in_range = (idx_ext < 32'(MAX_NODES));
    assign lim_ext      = ({{(32 - COUNT_W){1'b0}}, node_count} > 32'(MAX_NODES))
                          ? 32'(MAX_NODES) : {{(32 - COUNT_W){1'b0}}, node_count};
    assign lim          = lim_ext[CNT_W-1:0];
    assign pend_idx_ext = 32'(pend_idx_reg);

    // Table write on a write transfer; coordinates are sign-extended or wrapped.
    assign ram_we    = accept && (s_func == FUNC_WRITE) && idx_in_range;
    assign ram_waddr = idx_ext[ADDR_W-1:0];
    assign ram_wdata = {CW'(s_y), CW'(s_x)};

    // Read address: the queried node on acceptance, the scan pointer otherwise.
    assign ram_raddr = (state_reg == ST_IDLE) ? idx_ext[ADDR_W-1:0]
                                              : issue_reg[ADDR_W-1:0];

    // Compare the entry read back against the search target.
    assign rd_x     = ram_rdata[CW-1:0];
    assign rd_y     = ram_rdata[2*CW-1:CW];
    assign rd_x_ext = {rd_x[CW-1], rd_x};
    assign rd_y_ext = {rd_y[CW-1], rd_y};
    assign hit      = pend_valid_reg && (rd_x_ext == tx_reg) && (rd_y_ext == ty_reg);

    assign res.valid = (state_reg == ST_RESP);
    assign res.idx   = res_idx_reg;
    assign res.found = res_found_reg;

    // State and registered results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            chain_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        self_idx_reg  <= s_idx;
                        res_idx_reg   <= '0;
                        res_found_reg <= 1'b0;
                        if (s_func == FUNC_QUERY && idx_in_range) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            state_reg <= ST_RESP;
                        end
                    end
                end
                ST_LOAD: begin
                    // Pick the mirror plan from the queried node's position.
                    issue_reg      <= '0;
                    pend_valid_reg <= 1'b0;
                    chain_reg      <= 1'b0;
                    state_reg      <= ST_SCAN;
                    if (rd_x == NEG_V && rd_y == NEG_V) begin
                        tx_reg    <= rd_x_ext;
                        ty_reg    <= (CW + 1)'(0) - rd_y_ext;
                        chain_reg <= 1'b1;
                    end else if (rd_x == NEG_V && rd_y == ONE_V) begin
                        tx_reg <= (CW + 1)'(0) - rd_x_ext;
                        ty_reg <= rd_y_ext;
                    end else if (rd_x == ONE_V && rd_y == NEG_V) begin
                        tx_reg <= rd_x_ext;
                        ty_reg <= (CW + 1)'(0) - rd_y_ext;
                    end else if (rd_x == ONE_V || rd_x == NEG_V) begin
                        tx_reg <= (CW + 1)'(0) - rd_x_ext;
                        ty_reg <= rd_y_ext;
                    end else if (rd_y == ONE_V || rd_y == NEG_V) begin
                        tx_reg <= rd_x_ext;
                        ty_reg <= (CW + 1)'(0) - rd_y_ext;
                    end else begin
                        res_idx_reg   <= self_idx_reg;
                        res_found_reg <= 1'b1;
                        state_reg     <= ST_RESP;
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        pend_valid_reg <= 1'b0;
                        if (chain_reg) begin
                            // Corner: mirror the node just found in x.
                            tx_reg    <= (CW + 1)'(0) - tx_reg;
                            chain_reg <= 1'b0;
                            issue_reg <= '0;
                        end else begin
                            res_idx_reg   <= pend_idx_ext[IDX_W-1:0];
                            res_found_reg <= 1'b1;
                            state_reg     <= ST_RESP;
                        end
                    end else if (issue_reg >= lim) begin
                        // Table exhausted without a match.
                        pend_valid_reg <= 1'b0;
                        chain_reg      <= 1'b0;
                        state_reg      <= ST_RESP;
                    end else begin
                        pend_valid_reg <= 1'b1;
                        pend_idx_reg   <= issue_reg;
                        issue_reg      <= issue_reg + 1'b1;
                    end
                end
                ST_RESP: begin
                    if (res_take) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/periodic_mirror_node_match_top.sv =====
// Top level of the periodic mirror node match block: configuration register,
// output register and the node table. Depends on pmnm_pkg, pmnm_ram, pmnm_ctrl.
//
// Usage: the slave stream takes one item per transfer. s_tuser = 0 writes the
// coordinates in s_tdata into the node table at node_index; s_tuser = 1 asks
// for the periodic partner of node node_index. Every item yields exactly one
// transfer on the master stream: matched_index in m_tdata and found in m_tuser
// (write items answer zero with found low).
// cfg_wdata, written when cfg_we is high, sets how many table entries a search
// scans; write it only while no item is in flight.
// Timing: the sequencer holds one item at a time. Writes and queries of an
// ordinary node need no scan; a query needing one mirror scans up to N table
// entries and a corner query up to 2N, N being the scanned node count. The
// scan reads one table entry per cycle from a single read port. The output
// register is loaded as the sequencer frees up, so the result can leave at the
// same edge that takes the next item.
// Reset clears the node count, the sequencer and the output register; the
// table contents are undefined until written. When the receiver stalls, the
// held result keeps its value and a further finished result waits inside.
module periodic_mirror_node_match_top
    import pmnm_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input stream.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // node_index[9:0], coord_x[25:10], coord_y[41:26]
    input  logic               s_tuser,   // func[0]
    // Result stream.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // matched_index[9:0]
    output logic               m_tuser,   // found[0]
    // Configuration.
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata  // node_count
);

    localparam int ADDR_W = $clog2(MAX_NODES);

    logic [COUNT_W-1:0]       node_count_reg;
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_idx_reg;
    logic                     m_found_reg;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [2*COORD_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [2*COORD_WIDTH-1:0] ram_rdata;
    pmnm_res_t                res;
    logic                     out_free;
    logic                     res_take;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
        end
    end

    pmnm_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (MAX_NODES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pmnm_ctrl #(
        .MAX_NODES   (MAX_NODES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_func     (s_tuser),
        .s_idx      (s_tdata[9:0]),
        .s_x        (s_tdata[25:10]),
        .s_y        (s_tdata[41:26]),
        .node_count (node_count_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res        (res),
        .res_take   (res_take)
    );

    // Output register: loads a finished result once the previous one is gone.
    assign out_free = !m_valid_reg || m_tready;
    assign res_take = res.valid && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res.valid;
            if (res.valid) begin
                m_idx_reg   <= res.idx;
                m_found_reg <= res.found;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - IDX_W){1'b0}}, m_idx_reg};
    assign m_tuser  = m_found_reg;

    // The sequencer never takes an item while it still holds a result.
    a_ready_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !res.valid)
        else $error("input ready while a result is held");

    // One item at a time: an accepted transfer closes the input.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a transfer");

    // A failed or write result carries index zero.
    a_zero_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
        else $error("nonzero index without a match");

endmodule

// ===== dv/pmnm_checker.sv =====
// Checker for the periodic mirror node match block: watches both stream channels
// and the count register, predicts each partner answer and compares it on arrival.
// Depends on pmnm_pkg for field widths and item kinds.
module pmnm_checker
    import pmnm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [47:0]        s_tdata,   // node_index[9:0], coord_x[25:10], coord_y[41:26]
    input  logic               s_tuser,   // func[0]
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [15:0]        m_tdata,   // matched_index[9:0]
    input  logic               m_tuser,   // found[0]
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata, // node_count
    output int                 fail_count,
    output int                 pending
);

    localparam int TABLE_DEPTH = MAX_NODES_DEF;
    localparam int ONE_FX      = 1 << (COORD_WIDTH_DEF - 2);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             found;
    } partner_t;

    // Shadow copy of the node table and the scan length.
    int                 node_x [TABLE_DEPTH];
    int                 node_y [TABLE_DEPTH];
    logic [COUNT_W-1:0] scan_count;
    partner_t           expected_partners [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        scan_count = '0;
        for (int n = 0; n < TABLE_DEPTH; n++) begin
            node_x[n] = 0;
            node_y[n] = 0;
        end
    end

    // First entry within the scanned range that sits exactly at (tx, ty), or -1.
    function automatic int find_node(input int tx, input int ty);
        int lim;
        lim = (int'(scan_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
        for (int n = 0; n < lim; n++) begin
            if (node_x[n] == tx && node_y[n] == ty)
                return n;
        end
        return -1;
    endfunction

    // Applies one item to the shadow table and returns the answer it must produce.
    function automatic partner_t predict_partner(input logic func, input logic [IDX_W-1:0] idx,
                                                 input logic [15:0] cx, input logic [15:0] cy);
        partner_t res;
        int       x;
        int       y;
        int       r;
        res = '0;
        if (func == FUNC_WRITE) begin
            node_x[idx] = int'($signed(cx));
            node_y[idx] = int'($signed(cy));
            return res;
        end
        x = node_x[idx];
        y = node_y[idx];
        r = int'(idx);
        if (x == -ONE_FX && y == -ONE_FX) begin
            // Corner: mirror in y first, then mirror that node in x.
            r = find_node(x, -y);
            if (r >= 0)
                r = find_node(-node_x[r], node_y[r]);
        end else if (x == -ONE_FX && y == ONE_FX) begin
            r = find_node(-x, y);
        end else if (x == ONE_FX && y == -ONE_FX) begin
            r = find_node(x, -y);
        end else if (x == ONE_FX || x == -ONE_FX) begin
            r = find_node(-x, y);
        end else if (y == ONE_FX || y == -ONE_FX) begin
            r = find_node(x, -y);
        end
        if (r >= 0) begin
            res.idx   = r[IDX_W-1:0];
            res.found = 1'b1;
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        if (fail_count < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Predict on every input transfer, compare on every result transfer.
    always @(posedge aclk) begin
        partner_t exp_p;
        if (!aresetn) begin
            scan_count = '0;
        end else begin
            if (cfg_we)
                scan_count = cfg_wdata;
            if (s_tvalid && s_tready)
                expected_partners.push_back(predict_partner(s_tuser, s_tdata[IDX_W-1:0],
                                                             s_tdata[25:10], s_tdata[41:26]));
            if (m_tvalid && m_tready) begin
                if (expected_partners.size() == 0) begin
                    flag_error($sformatf("result with nothing expected: index %0d found %0b",
                                         m_tdata[IDX_W-1:0], m_tuser));
                end else begin
                    exp_p = expected_partners.pop_front();
                    if (m_tdata[IDX_W-1:0] !== exp_p.idx || m_tuser !== exp_p.found)
                        flag_error($sformatf("expected index %0d found %0b, got index %0d found %0b",
                                             exp_p.idx, exp_p.found, m_tdata[IDX_W-1:0], m_tuser));
                end
            end
        end
        pending = expected_partners.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the periodic mirror node match block: clock, reset, stimulus
// and verdict. Depends on pmnm_pkg, the block's top level and pmnm_checker.
module tb
    import pmnm_pkg::*;
;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ONE_FX      = 1 << (COORD_WIDTH_DEF - 2);

    localparam logic [15:0] POS_ONE  = 16'h4000;
    localparam logic [15:0] NEG_ONE  = 16'hC000;
    localparam logic [15:0] C_ZERO   = 16'h0000;
    localparam logic [15:0] MOST_NEG = 16'h8000;
    localparam logic [15:0] MOST_POS = 16'h7FFF;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;
    logic               m_tuser;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;

    // Stimulus bookkeeping: which entries hold data, so no unwritten entry is read.
    bit written_map [MAX_NODES_DEF];
    int written_list [$];
    int burst_left    = 0;
    int writes_sent   = 0;
    int queries_sent  = 0;
    int count_changes = 0;
    int cycle_count   = 0;
    int stall_mode    = 0;
    int mode_left     = 0;

    always #5 aclk = ~aclk;

    periodic_mirror_node_match_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    pmnm_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver backpressure: always ready, coin flip, or long stalls, switching now and then.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Coordinate on a mesh of the given number of levels across [-1,1], with some noise.
    function automatic logic [15:0] mesh_coord(input int levels);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return 16'(-ONE_FX + int'($urandom_range(0, levels - 1)) * (2 * ONE_FX / (levels - 1)));
        else if (pick < 90)
            return 16'($urandom);
        else if (pick < 95)
            return MOST_NEG;
        else
            return MOST_POS;
    endfunction

    // One input transfer, preceded by a random gap at the start of each burst.
    task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                             input logic [15:0] cx, input logic [15:0] cy);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'b0, cy, cx, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_node(input int idx, input logic [15:0] cx, input logic [15:0] cy);
        if (!written_map[idx]) begin
            written_map[idx] = 1'b1;
            written_list.push_back(idx);
        end
        writes_sent++;
        send_item(FUNC_WRITE, idx[IDX_W-1:0], cx, cy);
    endtask

    // Query coordinates are ignored by the block, so they carry random bits.
    task automatic query_node(input int idx);
        queries_sent++;
        send_item(FUNC_QUERY, idx[IDX_W-1:0], 16'($urandom), 16'($urandom));
    endtask

    // Waits until every answer is in, then lets the block settle.
    task automatic wait_idle();
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Count register write, only with the block drained.
    task automatic set_count(input int n);
        s_tvalid <= 1'b0;
        burst_left = 0;
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= n[COUNT_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        count_changes++;
    endtask

    initial begin
        int n;
        int idx;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: an empty scan range first, so mirrored nodes cannot resolve.
        set_count(0);
        write_node(0, C_ZERO, C_ZERO);
        query_node(0);
        write_node(1, NEG_ONE, C_ZERO);
        query_node(1);

        // Directed: the four corners, the edge midpoints and their partners.
        set_count(8);
        write_node(0, NEG_ONE, NEG_ONE);
        write_node(1, NEG_ONE, POS_ONE);
        write_node(2, POS_ONE, NEG_ONE);
        write_node(3, POS_ONE, POS_ONE);
        write_node(4, NEG_ONE, C_ZERO);
        write_node(5, POS_ONE, C_ZERO);
        write_node(6, C_ZERO, POS_ONE);
        write_node(7, C_ZERO, NEG_ONE);
        for (int k = 0; k < 8; k++)
            query_node(k);
        // Nodes above the scan range, with extreme coordinates; the edge node has no partner.
        write_node(9, POS_ONE, MOST_NEG);
        query_node(9);
        write_node(1023, MOST_POS, MOST_NEG);
        query_node(1023);

        // Random phases with small tables: fill the scanned range, then mix traffic.
        for (int ph = 0; ph < 6; ph++) begin
            n = (ph == 0) ? 1 : $urandom_range(2, 40);
            set_count(n);
            for (int k = 0; k < n; k++)
                write_node(k, mesh_coord(5), mesh_coord(5));
            for (int k = 0; k < 26; k++) begin
                if ($urandom_range(0, 99) < 55) begin
                    if ($urandom_range(0, 4) != 0)
                        query_node($urandom_range(0, n - 1));
                    else
                        query_node(written_list[$urandom_range(0, written_list.size() - 1)]);
                end else begin
                    if ($urandom_range(0, 3) != 0)
                        idx = $urandom_range(0, n - 1);
                    else
                        idx = $urandom_range(0, MAX_NODES_DEF - 1);
                    write_node(idx, mesh_coord(5), mesh_coord(5));
                end
            end
        end

        // A count beyond the table depth: every corner query resolves within the
        // first entries, so the scans never reach an unwritten one.
        set_count((1 << COUNT_W) - 1);
        write_node(0, NEG_ONE, NEG_ONE);
        write_node(1, NEG_ONE, POS_ONE);
        write_node(2, POS_ONE, NEG_ONE);
        write_node(3, POS_ONE, POS_ONE);
        for (int k = 0; k < 4; k++)
            query_node(k);

        s_tvalid <= 1'b0;
        wait_idle();
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        $display("Run covered %0d table writes and %0d partner queries over %0d node counts,",
                 writes_sent, queries_sent, count_changes);
        $display("from an empty scan range up to a count beyond the table depth.");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
